@@ hdl/tfb_pkg.sv @@
// Shared types and constants for the telemetry frame builder.
// No dependencies; imported by every module in hdl/.
package tfb_pkg;

  localparam int          WORD_W        = 16;
  localparam int          ID_W          = 8;
  localparam int          COUNT_W       = 7;
  localparam int          BYTE_W        = 8;
  localparam int          IN_DATA_W     = 32;
  localparam int          PKT_BYTES     = 8;
  localparam int          PKT_IDX_W     = $clog2(PKT_BYTES);
  localparam int          PKT_LEN_W     = $clog2(PKT_BYTES + 1);
  localparam int          HDR_COUNTED   = 6;
  localparam int          MAX_WORDS_DEF = 127;

  localparam logic [BYTE_W-1:0] SYNC_A = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'hFF;

  // Bytes caused by one input transaction, lowest index sent first.
  typedef struct packed {
    logic [PKT_BYTES-1:0][BYTE_W-1:0] data;
    logic [PKT_LEN_W-1:0]             len;
    logic                             closes;
  } pkt_t;

endpackage

@@ hdl/tfb_frame_calc.sv @@
// Frame state (sums, words left) and the single-pass byte list for one word.
// Depends on tfb_pkg.
module tfb_frame_calc #(
  parameter int MAX_WORDS = tfb_pkg::MAX_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [tfb_pkg::WORD_W-1:0]   word_value,
  input  logic [tfb_pkg::ID_W-1:0]     frame_id,
  input  logic [tfb_pkg::COUNT_W-1:0]  word_count,
  output tfb_pkg::pkt_t                pkt
);
  import tfb_pkg::*;

  logic [BYTE_W-1:0]                    byte_sum;
  logic [BYTE_W-1:0]                    sum_of_sums;
  logic [COUNT_W-1:0]                   words_left;

  logic [COUNT_W-1:0]                   cnt;
  logic                                 starting;
  logic [HDR_COUNTED-1:0][BYTE_W-1:0]   cb;
  logic [BYTE_W-1:0]                    bs;
  logic [BYTE_W-1:0]                    ss;
  logic [COUNT_W-1:0]                   words_left_next;
  logic                                 last;

  always_comb begin
    cnt = (word_count == '0) ? COUNT_W'(1) : word_count;
    if (int'(cnt) > MAX_WORDS) cnt = COUNT_W'(MAX_WORDS);
    starting = (words_left == '0);

    cb = '0;
    if (starting) begin
      cb[0] = SYNC_A;
      cb[1] = SYNC_B;
      cb[2] = frame_id;
      cb[3] = {cnt, 1'b0};
      cb[4] = word_value[7:0];
      cb[5] = word_value[15:8];
    end else begin
      cb[0] = word_value[7:0];
      cb[1] = word_value[15:8];
    end

    bs = starting ? '0 : byte_sum;
    ss = starting ? '0 : sum_of_sums;
    for (int i = 0; i < HDR_COUNTED; i++) begin
      if (starting || i < 2) begin
        bs = bs + cb[i];
        ss = ss + bs;
      end
    end

    words_left_next = starting ? (cnt - COUNT_W'(1)) : (words_left - COUNT_W'(1));
    last            = (words_left_next == '0);

    pkt.data = '0;
    for (int i = 0; i < HDR_COUNTED; i++) begin
      pkt.data[i] = cb[i];
    end
    if (starting) begin
      pkt.data[6] = bs;
      pkt.data[7] = ss;
      pkt.len     = PKT_LEN_W'(last ? 8 : 6);
    end else begin
      pkt.data[2] = bs;
      pkt.data[3] = ss;
      pkt.len     = PKT_LEN_W'(last ? 4 : 2);
    end
    pkt.closes = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_sum    <= '0;
      sum_of_sums <= '0;
      words_left  <= '0;
    end else if (take) begin
      byte_sum    <= last ? '0 : bs;
      sum_of_sums <= last ? '0 : ss;
      words_left  <= words_left_next;
    end
  end

endmodule

@@ hdl/tfb_serializer.sv @@
// Holds one byte list and sends it out one byte per cycle while m_tready is high.
// Depends on tfb_pkg.
module tfb_serializer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  tfb_pkg::pkt_t              pkt_in,
  output logic                       can_load,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [tfb_pkg::BYTE_W-1:0] out_byte,
  output logic                       frame_end,
  output logic                       run_end
);
  import tfb_pkg::*;

  logic                 valid;
  pkt_t                 pkt;
  logic [PKT_IDX_W-1:0] idx;
  logic                 at_last;
  logic                 fire;

  assign at_last   = (PKT_LEN_W'(idx) + PKT_LEN_W'(1) == pkt.len);
  assign fire      = valid && m_tready;
  assign can_load  = !valid || (at_last && m_tready);
  assign m_tvalid  = valid;
  assign out_byte  = pkt.data[idx];
  assign run_end   = at_last;
  assign frame_end = at_last && pkt.closes;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (fire && at_last) begin
      valid <= 1'b0;
    end else if (fire) begin
      idx <= idx + PKT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) pkt <= pkt_in;
  end

endmodule

@@ hdl/telemetry_frame_builder.sv @@
// Telemetry frame builder top level: input handshake, frame state, byte output.
// Depends on tfb_pkg, tfb_frame_calc and tfb_serializer.
//
// Slave stream: one transaction per 16-bit telemetry word. The first word of
// a frame also carries the frame id and word count (0 counts as 1, counts
// above MAX_WORDS saturate). Master stream: one byte per transaction.
// The first word of a frame yields AA, FF, id, 2*count, low, high; other
// words yield low, high; the last word of a frame adds the byte sum and the
// sum of partial sums. tlast marks the final check byte, tuser[0] the last
// byte caused by a word.
// Latency: the first byte of a word appears the cycle after its transaction.
// Throughput: one byte per cycle while m_tready is high, set by the
// single byte-list register; the next word is taken in the cycle its
// predecessor's last byte is taken, so no bubbles appear.
// Reset: output empty, next word opens a new frame.
// Stall: while m_tready is low the current byte holds and s_tready stays low unless the output is empty.
module telemetry_frame_builder #(
  parameter int MAX_WORDS = tfb_pkg::MAX_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] word_value, [23:16] frame_id, [30:24] word_count, [31] zero
  input  logic [tfb_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] out_byte
  output logic [tfb_pkg::BYTE_W-1:0]      m_tdata,
  output logic                            m_tlast,
  // [0] run_end
  output logic [0:0]                      m_tuser
);
  import tfb_pkg::*;

  logic take;
  pkt_t pkt;
  logic can_load;

  assign s_tready = can_load;
  assign take     = s_tvalid && can_load;

  tfb_frame_calc #(
    .MAX_WORDS (MAX_WORDS)
  ) u_calc (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .word_value (s_tdata[15:0]),
    .frame_id   (s_tdata[23:16]),
    .word_count (s_tdata[30:24]),
    .pkt        (pkt)
  );

  tfb_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .pkt_in    (pkt),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_byte  (m_tdata),
    .frame_end (m_tlast),
    .run_end   (m_tuser[0])
  );

  a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[0])
    else $error("frame end not on last byte of a word");

  a_take_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (s_tready && m_tvalid) |-> m_tuser[0])
    else $error("new word taken before current bytes finished");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
